// File: rtl/rft_pkg.sv
// shared types and constants for the first-match rule table
package rft_pkg;

	localparam int PORT_W     = 16;
	localparam int HIT_POS_W  = 6;
	localparam int REMOVED_W  = 7;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_PLACE
	} state_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] src_mask;
		logic [31:0] dst_addr;
		logic [31:0] dst_mask;
		logic [31:0] src_ports;
		logic [31:0] dst_ports;
		logic [7:0]  proto;
		logic        action;
		logic [15:0] tag;
	} rule_t;

endpackage

// File: rtl/first_match_packet_rule_table_core.sv
// first-match rule table: sequencer, rule memory and shared compare unit
//
//   channel | signals                    | direction | carries
//   --------+----------------------------+-----------+------------------------
//   request | in_valid / in_ready        | into      | one request word
//   result  | out_valid / out_ready      | out of    | one result word
//
// each word walks the table one entry per cycle through a single read port.
// a lookup or delete scans the entries; an insert finds its slot (skipped at head or
// on an empty table), then shifts the tail down one entry per cycle, then places.
// reset clears the rule count; stored entries are never read until written.
// a new request is taken only when idle and the result register is empty.
module first_match_packet_rule_table_core #(
	parameter int MAX_RULES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] src_addr,
	input  logic [31:0] src_mask,
	input  logic [31:0] dst_addr,
	input  logic [31:0] dst_mask,
	input  logic [31:0] src_port_range,
	input  logic [31:0] dst_port_range,
	input  logic [7:0]  protocol,
	input  logic        verdict,
	input  logic [15:0] rule_tag,
	input  logic [15:0] after_tag,
	input  logic        at_head,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic        matched,
	output logic        hit_verdict,
	output logic [15:0] hit_tag,
	output logic [5:0]  hit_position,
	output logic [6:0]  removed_count
);

	localparam int AW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CW  = $clog2(MAX_RULES + 1);
	localparam int PW  = rft_pkg::PORT_W;
	localparam int HPW = rft_pkg::HIT_POS_W;
	localparam int RMW = rft_pkg::REMOVED_W;

	rft_pkg::state_t state_q, state_d;

	// held request
	rft_pkg::req_t  req_q;
	rft_pkg::rule_t item_q;
	logic [15:0]    after_q;

	// scan counters
	logic [CW-1:0] n_q, n_d;
	logic [CW-1:0] rd_q, rd_d;
	logic [CW-1:0] w_q, w_d;
	logic [CW-1:0] rem_q, rem_d;
	logic [CW-1:0] pos_q, pos_d;
	logic          vld_s1, vld_d;
	logic [AW-1:0] idx_s1, idx_d;

	// memory port
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	rft_pkg::rule_t mem_wdata;
	logic [AW-1:0]  mem_raddr;
	rft_pkg::rule_t rd_data;

	// result
	logic          fin;
	logic          res_ok;
	logic          res_matched;
	logic          res_verdict;
	logic [15:0]   res_tag;
	logic [HPW-1:0] res_pos;
	logic [RMW-1:0] res_removed;
	logic          out_valid_q;

	logic            hit;
	logic            found;
	logic [CW-1:0]   rd_dec;
	logic [AW+HPW-1:0] pos_ext;
	logic [CW+RMW-1:0] rem_ext;
	logic            accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == rft_pkg::ST_IDLE) && !out_valid_q;
	assign rd_dec   = rd_q - CW'(1);
	assign pos_ext  = {{HPW{1'b0}}, idx_s1};
	assign rem_ext  = {{RMW{1'b0}}, rem_q};

	rft_mem #(
		.DEPTH (MAX_RULES),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	rft_match u_match (
		.rule     (rd_data),
		.src_addr (item_q.src_addr),
		.dst_addr (item_q.dst_addr),
		.src_port (item_q.src_ports[PW-1:0]),
		.dst_port (item_q.dst_ports[PW-1:0]),
		.protocol (item_q.proto),
		.hit      (hit)
	);

	// entry under test ends the scan
	assign found = vld_s1 &&
		(((req_q == rft_pkg::REQ_LOOKUP) && hit) ||
		((req_q == rft_pkg::REQ_INSERT) && (rd_data.tag == after_q)));

	// sequencer: next state, counters and memory control
	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		rd_d        = rd_q;
		w_d         = w_q;
		rem_d       = rem_q;
		pos_d       = pos_q;
		vld_d       = 1'b0;
		idx_d       = idx_s1;
		mem_we      = 1'b0;
		mem_waddr   = w_q[AW-1:0];
		mem_wdata   = rd_data;
		mem_raddr   = rd_q[AW-1:0];
		fin         = 1'b0;
		res_ok      = 1'b0;
		res_matched = 1'b0;
		res_verdict = 1'b0;
		res_tag     = '0;
		res_pos     = '0;
		res_removed = '0;
		case (state_q)
			rft_pkg::ST_IDLE: begin
				if (accept) begin
					rd_d  = '0;
					w_d   = '0;
					rem_d = '0;
					pos_d = '0;
					case (rft_pkg::req_t'(req_type))
						rft_pkg::REQ_LOOKUP, rft_pkg::REQ_DELETE: begin
							state_d = rft_pkg::ST_SCAN;
						end
						rft_pkg::REQ_INSERT: begin
							if (n_q == CW'(MAX_RULES)) begin
								fin = 1'b1;
							end else if ((n_q == '0) || at_head) begin
								rd_d    = n_q;
								state_d = rft_pkg::ST_SHIFT;
							end else begin
								state_d = rft_pkg::ST_SCAN;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			rft_pkg::ST_SCAN: begin
				if (found) begin
					if (req_q == rft_pkg::REQ_LOOKUP) begin
						fin         = 1'b1;
						res_ok      = 1'b1;
						res_matched = 1'b1;
						res_verdict = rd_data.action;
						res_tag     = rd_data.tag;
						res_pos     = pos_ext[HPW-1:0];
						state_d     = rft_pkg::ST_IDLE;
					end else begin
						pos_d   = CW'(idx_s1) + CW'(1);
						rd_d    = n_q;
						state_d = rft_pkg::ST_SHIFT;
					end
				end else begin
					// delete compacts the kept entries in place
					if (vld_s1 && (req_q == rft_pkg::REQ_DELETE)) begin
						if (rd_data.tag == item_q.tag) begin
							rem_d = rem_q + CW'(1);
						end else begin
							mem_we = 1'b1;
							w_d    = w_q + CW'(1);
						end
					end
					if (rd_q < n_q) begin
						vld_d = 1'b1;
						idx_d = rd_q[AW-1:0];
						rd_d  = rd_q + CW'(1);
					end else if (!vld_s1) begin
						fin     = 1'b1;
						state_d = rft_pkg::ST_IDLE;
						case (req_q)
							rft_pkg::REQ_LOOKUP: begin
								res_ok = 1'b1;
							end
							rft_pkg::REQ_DELETE: begin
								res_ok      = 1'b1;
								res_removed = rem_ext[RMW-1:0];
								n_d         = w_q;
							end
							default: begin
								res_ok = 1'b0;
							end
						endcase
					end
				end
			end
			rft_pkg::ST_SHIFT: begin
				// move entry i-1 to i, from the tail down to the slot
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1 + AW'(1);
				end
				if (rd_q > pos_q) begin
					mem_raddr = rd_dec[AW-1:0];
					vld_d     = 1'b1;
					idx_d     = rd_dec[AW-1:0];
					rd_d      = rd_dec;
				end else if (!vld_s1) begin
					state_d = rft_pkg::ST_PLACE;
				end
			end
			rft_pkg::ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = item_q;
				n_d       = n_q + CW'(1);
				fin       = 1'b1;
				res_ok    = 1'b1;
				state_d   = rft_pkg::ST_IDLE;
			end
			default: begin
				state_d = rft_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rft_pkg::ST_IDLE;
			n_q         <= '0;
			rd_q        <= '0;
			w_q         <= '0;
			rem_q       <= '0;
			pos_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			rd_q    <= rd_d;
			w_q     <= w_d;
			rem_q   <= rem_d;
			pos_q   <= pos_d;
			vld_s1  <= vld_d;
			idx_s1  <= idx_d;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request word capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q            <= rft_pkg::req_t'(req_type);
			item_q.src_addr  <= src_addr;
			item_q.src_mask  <= src_mask;
			item_q.dst_addr  <= dst_addr;
			item_q.dst_mask  <= dst_mask;
			item_q.src_ports <= src_port_range;
			item_q.dst_ports <= dst_port_range;
			item_q.proto     <= protocol;
			item_q.action    <= verdict;
			item_q.tag       <= rule_tag;
			after_q          <= after_tag;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (fin) begin
			ok            <= res_ok;
			matched       <= res_matched;
			hit_verdict   <= res_verdict;
			hit_tag       <= res_tag;
			hit_position  <= res_pos;
			removed_count <= res_removed;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/rft_mem.sv
// rule storage: one write port, one registered read port
module rft_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  rft_pkg::rule_t wdata,
	input  logic [AW-1:0]  raddr,
	output rft_pkg::rule_t rdata
);

	rft_pkg::rule_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/rft_match.sv
// compares one stored rule against the packet key
module rft_match (
	input  rft_pkg::rule_t                rule,
	input  logic [31:0]                   src_addr,
	input  logic [31:0]                   dst_addr,
	input  logic [rft_pkg::PORT_W-1:0]    src_port,
	input  logic [rft_pkg::PORT_W-1:0]    dst_port,
	input  logic [7:0]                    protocol,
	output logic                          hit
);

	localparam int PW = rft_pkg::PORT_W;

	logic src_ok;
	logic dst_ok;
	logic sp_ok;
	logic dp_ok;
	logic pr_ok;

	// address under mask
	assign src_ok = (src_addr & rule.src_mask) == (rule.src_addr & rule.src_mask);
	assign dst_ok = (dst_addr & rule.dst_mask) == (rule.dst_addr & rule.dst_mask);

	// port ranges, low in upper half, high in lower half
	assign sp_ok = (src_port >= rule.src_ports[2*PW-1:PW]) &&
		(src_port <= rule.src_ports[PW-1:0]);
	assign dp_ok = (dst_port >= rule.dst_ports[2*PW-1:PW]) &&
		(dst_port <= rule.dst_ports[PW-1:0]);

	// zero protocol is a wildcard
	assign pr_ok = (rule.proto == 8'd0) || (rule.proto == protocol);

	assign hit = src_ok && dst_ok && sp_ok && dp_ok && pr_ok;

endmodule

// File: tb/tb_first_match_packet_rule_table_core.sv
// testbench for the first-match rule table: directed and random requests checked against a table model
module tb_first_match_packet_rule_table_core;

	localparam int MAX_RULES = 64;

	typedef struct {
		logic       ok;
		logic       matched;
		logic       hit_verdict;
		logic [15:0] hit_tag;
		logic [5:0] hit_position;
		logic [6:0] removed_count;
	} verdict_word_t;

	// table model and queue of expected result words
	class rule_table_board;
		rft_pkg::rule_t rules[MAX_RULES];
		int            count;
		verdict_word_t pending[$];
		int            errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function bit port_ok(logic [15:0] port, logic [31:0] range);
			return port >= range[31:16] && port <= range[15:0];
		endfunction

		// apply an accepted request word and queue its result
		function void note_request(rft_pkg::req_t req, rft_pkg::rule_t r, logic at_head_in,
			logic [15:0] after);
			verdict_word_t v;
			int pos;
			bit place;
			int w;
			v = '{default: '0};
			pos = 0;
			place = 1'b0;
			w = 0;
			case (req)
				rft_pkg::REQ_LOOKUP: begin
					v.ok = 1'b1;
					for (int i = 0; i < count; i++) begin
						if (((r.src_addr & rules[i].src_mask) ==
							(rules[i].src_addr & rules[i].src_mask)) &&
							((r.dst_addr & rules[i].dst_mask) ==
							(rules[i].dst_addr & rules[i].dst_mask)) &&
							port_ok(r.src_ports[15:0], rules[i].src_ports) &&
							port_ok(r.dst_ports[15:0], rules[i].dst_ports) &&
							(rules[i].proto == 8'd0 || rules[i].proto == r.proto)) begin
							v.matched = 1'b1;
							v.hit_verdict = rules[i].action;
							v.hit_tag = rules[i].tag;
							v.hit_position = i[5:0];
							break;
						end
					end
				end
				rft_pkg::REQ_INSERT: begin
					if (count == 0 || at_head_in) begin
						place = count < MAX_RULES;
					end else if (count < MAX_RULES) begin
						for (int i = 0; i < count; i++) begin
							if (rules[i].tag == after) begin
								pos = i + 1;
								place = 1'b1;
								break;
							end
						end
					end
					if (place) begin
						for (int i = count; i > pos; i--) rules[i] = rules[i-1];
						rules[pos] = r;
						count++;
						v.ok = 1'b1;
					end
				end
				rft_pkg::REQ_DELETE: begin
					v.ok = 1'b1;
					for (int i = 0; i < count; i++) begin
						if (rules[i].tag == r.tag) begin
							v.removed_count++;
						end else begin
							rules[w] = rules[i];
							w++;
						end
					end
					count = w;
				end
				default: ;
			endcase
			pending.push_back(v);
		endfunction

		task check_result(verdict_word_t got);
			verdict_word_t e;
			if (pending.size() == 0) begin
				report_mismatch("result word with nothing expected");
				return;
			end
			e = pending.pop_front();
			if (got.ok !== e.ok) report_mismatch($sformatf("ok %0b exp %0b", got.ok, e.ok));
			if (got.matched !== e.matched)
				report_mismatch($sformatf("matched %0b exp %0b", got.matched, e.matched));
			if (got.hit_verdict !== e.hit_verdict)
				report_mismatch($sformatf("hit_verdict %0b exp %0b", got.hit_verdict,
					e.hit_verdict));
			if (got.hit_tag !== e.hit_tag)
				report_mismatch($sformatf("hit_tag %0h exp %0h", got.hit_tag, e.hit_tag));
			if (got.hit_position !== e.hit_position)
				report_mismatch($sformatf("hit_position %0d exp %0d", got.hit_position,
					e.hit_position));
			if (got.removed_count !== e.removed_count)
				report_mismatch($sformatf("removed_count %0d exp %0d", got.removed_count,
					e.removed_count));
		endtask

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [31:0] src_addr;
	logic [31:0] src_mask;
	logic [31:0] dst_addr;
	logic [31:0] dst_mask;
	logic [31:0] src_port_range;
	logic [31:0] dst_port_range;
	logic [7:0]  protocol;
	logic        verdict;
	logic [15:0] rule_tag;
	logic [15:0] after_tag;
	logic        at_head;
	logic        out_valid;
	logic        out_ready;
	logic        ok;
	logic        matched;
	logic        hit_verdict;
	logic [15:0] hit_tag;
	logic [5:0]  hit_position;
	logic [6:0]  removed_count;

	rule_table_board board;
	int send_idle_pct;
	int recv_stall_pct;

	first_match_packet_rule_table_core #(.MAX_RULES(MAX_RULES)) DUT (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// tag pool kept small so deletes and after-tag hits collide
	function automatic logic [15:0] pick_tag();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [31:0] pick_mask();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'hFFFFFFFF;
			2: return $urandom;
			default: return 32'hFFFFFFFF << $urandom_range(8, 28);
		endcase
	endfunction

	function automatic logic [31:0] pick_range();
		logic [15:0] lo;
		logic [15:0] hi;
		lo = 16'($urandom);
		hi = 16'($urandom);
		case ($urandom_range(0, 4))
			0: return {16'h0000, 16'hFFFF};
			1: return {hi, lo};
			default: return (lo <= hi) ? {lo, hi} : {hi, lo};
		endcase
	endfunction

	// one request word, held until accepted; valid drops only in idle cycles
	task automatic send_word(rft_pkg::req_t req, logic [31:0] sa, logic [31:0] sm,
		logic [31:0] da, logic [31:0] dm, logic [31:0] sp, logic [31:0] dp,
		logic [7:0] pr, logic vd, logic [15:0] tg, logic [15:0] af, logic hd);
		rft_pkg::rule_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		req_type <= req;
		src_addr <= sa;
		src_mask <= sm;
		dst_addr <= da;
		dst_mask <= dm;
		src_port_range <= sp;
		dst_port_range <= dp;
		protocol <= pr;
		verdict <= vd;
		rule_tag <= tg;
		after_tag <= af;
		at_head <= hd;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		r = '{src_addr: sa, src_mask: sm, dst_addr: da, dst_mask: dm,
			src_ports: sp, dst_ports: dp, proto: pr, action: vd, tag: tg};
		board.note_request(req, r, hd, af);
		@(negedge clk);
	endtask

	// random rule insert
	task automatic insert_rule();
		send_word(rft_pkg::REQ_INSERT, $urandom, pick_mask(), $urandom, pick_mask(),
			pick_range(), pick_range(),
			($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 3)),
			1'($urandom), pick_tag(), pick_tag(), 1'($urandom_range(0, 3) == 0));
	endtask

	// lookup, usually aimed at a stored rule so matches happen
	task automatic lookup_packet();
		logic [31:0] sa;
		logic [31:0] da;
		logic [31:0] sp;
		logic [31:0] dp;
		int k;
		sa = $urandom;
		da = $urandom;
		sp = $urandom;
		dp = $urandom;
		if (board.count > 0 && $urandom_range(0, 3) != 0) begin
			k = $urandom_range(0, board.count - 1);
			sa = (board.rules[k].src_addr & board.rules[k].src_mask) |
				(sa & ~board.rules[k].src_mask);
			da = (board.rules[k].dst_addr & board.rules[k].dst_mask) |
				(da & ~board.rules[k].dst_mask);
			sp[15:0] = $urandom_range(0, 1) ? board.rules[k].src_ports[31:16]
				: board.rules[k].src_ports[15:0];
			dp[15:0] = $urandom_range(0, 1) ? board.rules[k].dst_ports[15:0]
				: board.rules[k].dst_ports[31:16];
		end
		send_word(rft_pkg::REQ_LOOKUP, sa, $urandom, da, $urandom, sp, dp,
			8'($urandom_range(0, 3)), 1'($urandom), 16'($urandom), 16'($urandom),
			1'($urandom));
	endtask

	task automatic random_word();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) insert_rule();
		else if (sel < 85) lookup_packet();
		else if (sel < 97)
			send_word(rft_pkg::REQ_DELETE, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, 8'($urandom), 1'($urandom), pick_tag(),
				16'($urandom), 1'($urandom));
		else
			send_word(rft_pkg::REQ_NONE, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, 8'($urandom), 1'($urandom), 16'($urandom),
				16'($urandom), 1'($urandom));
	endtask

	// result side: random stall, sample at rising edge
	always @(negedge clk) begin
		if (arst_n) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result('{ok: ok, matched: matched, hit_verdict: hit_verdict,
				hit_tag: hit_tag, hit_position: hit_position,
				removed_count: removed_count});
	end

	// stimulus
	initial begin
		board = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		req_type = rft_pkg::REQ_LOOKUP;
		src_addr = '0;
		src_mask = '0;
		dst_addr = '0;
		dst_mask = '0;
		src_port_range = '0;
		dst_port_range = '0;
		protocol = '0;
		verdict = 1'b0;
		rule_tag = '0;
		after_tag = '0;
		at_head = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, insert on empty with missing tag, extremes
		send_word(rft_pkg::REQ_LOOKUP, '1, '1, '1, '1, '1, '1, 8'hFF, 1'b1, 16'hFFFF,
			16'hFFFF, 1'b1);
		send_word(rft_pkg::REQ_DELETE, '0, '0, '0, '0, '0, '0, '0, 1'b0, 16'h0005, '0,
			1'b0);
		send_word(rft_pkg::REQ_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0,
			{16'h0000, 16'hFFFF}, {16'h0000, 16'hFFFF}, 8'd0, 1'b1, 16'hFFFF, 16'h1234,
			1'b0);
		send_word(rft_pkg::REQ_INSERT, 32'hAAAAAAAA, 32'hFFFF0000, 32'h55555555,
			32'hFFFFFFFF, {16'd100, 16'd200}, {16'd80, 16'd80}, 8'hFF, 1'b0, 16'h0000,
			16'hFFFF, 1'b0);
		send_word(rft_pkg::REQ_INSERT, '0, '0, '0, '0, {16'd500, 16'd100},
			{16'h0, 16'hFFFF}, 8'd6, 1'b1, 16'h0007, 16'h0000, 1'b1);
		send_word(rft_pkg::REQ_INSERT, '0, '0, '0, '0, '0, '0, '0, 1'b0, 16'h0009,
			16'h4242, 1'b0);
		send_word(rft_pkg::REQ_LOOKUP, 32'hAAAA1234, '0, 32'h55555555, '0,
			{16'hFFFF, 16'd100}, {16'h0, 16'd80}, 8'hFF, 1'b0, '0, '0, 1'b0);
		send_word(rft_pkg::REQ_LOOKUP, 32'hAAAA1234, '0, 32'h55555555, '0, 32'd300,
			32'd80, 8'd6, 1'b0, '0, '0, 1'b0);
		send_word(rft_pkg::REQ_LOOKUP, '0, '0, '0, '0, 32'd0, 32'hFFFF, 8'd0, 1'b0, '0,
			'0, 1'b0);
		send_word(rft_pkg::REQ_NONE, '1, '1, '1, '1, '1, '1, 8'hFF, 1'b1, 16'hFFFF,
			16'hFFFF, 1'b1);
		send_word(rft_pkg::REQ_DELETE, '0, '0, '0, '0, '0, '0, '0, 1'b0, 16'hFFFF, '0,
			1'b0);
		send_word(rft_pkg::REQ_DELETE, '0, '0, '0, '0, '0, '0, '0, 1'b0, 16'h0000, '0,
			1'b0);
		// fill to full, then one more at head and after a tag
		while (board.count < MAX_RULES)
			send_word(rft_pkg::REQ_INSERT, $urandom, pick_mask(), $urandom, pick_mask(),
				pick_range(), pick_range(), 8'd0, 1'($urandom), 16'h0003, 16'h0, 1'b1);
		send_word(rft_pkg::REQ_INSERT, '0, '0, '0, '0, '0, '0, '0, 1'b1, 16'h0004,
			16'h0003, 1'b1);
		send_word(rft_pkg::REQ_INSERT, '0, '0, '0, '0, '0, '0, '0, 1'b1, 16'h0004,
			16'h0003, 1'b0);
		send_word(rft_pkg::REQ_LOOKUP, '0, '0, '0, '0, '0, '0, 8'd1, 1'b0, '0, '0, 1'b0);
		send_word(rft_pkg::REQ_DELETE, '0, '0, '0, '0, '0, '0, '0, 1'b0, 16'h0003, '0,
			1'b0);

		// random phases with different idle patterns
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			for (int n = 0; n < 125; n++) random_word();
		end
		in_valid <= 1'b0;

		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
rtl/rft_pkg.sv
rtl/rft_mem.sv
rtl/rft_match.sv
rtl/first_match_packet_rule_table_core.sv
tb/tb_first_match_packet_rule_table_core.sv
